// File: rtl/core/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, codes and default sizes for the set-associative LRU cache core.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_WIDTH   = 48;
   localparam int DEF_COUNT_WIDTH  = 32;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SET_BITS    = 2'd0,
      REG_WAYS_IN_USE = 2'd1,
      REG_BLOCK_BITS  = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_MODIFY = 2'd2,
      ACT_IFETCH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OUT_HIT        = 2'd0,
      OUT_MISS_FREE  = 2'd1,
      OUT_MISS_EVICT = 2'd2,
      OUT_IGNORED    = 2'd3
   } outcome_type;

endpackage

// File: rtl/core/set_assoc_lru_cache_sim_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// Set-associative cache model with LRU replacement, one trace access per item.
// ----------------------------------------------------------------------------
// Takes one access per cycle while the result output is not stalled; an
// accepted access passes the lookup stage and its result is then registered.
// Each set is one row of a single-port-per-direction memory (valid bits, LRU
// ranks and tags of all ways); an item reads its row on acceptance and writes
// it back when its lookup finishes. An access accepted while the last item to
// the same set finishes is served from a forwarded copy of the row. After
// reset and after every write to a known register, a clearing sweep zeroes
// all 2**MAX_SET_BITS rows (64 by default), a row per cycle, with req_tready
// low. Result counts are the running totals after the item and saturate.
module set_assoc_lru_cache_sim_core
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   // tuser: action[1:0]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [1:0]                   req_tuser,
   // tdata: address[ADDR_WIDTH-1:0], zero padded to bytes
   input  logic [((ADDR_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: outcome[1:0], extra_hit[2]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [2:0]                   rsp_tuser,
   // tdata: hit_count, miss_count, evict_count (COUNT_WIDTH each), zero padded
   output logic [((3*COUNT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int ROWS    = 1 << MAX_SET_BITS;
   localparam int IDX_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int OA_W    = AGE_W + 1;
   localparam int WN_W    = $clog2(MAX_WAYS + 1);
   localparam int SBE_W   = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
   localparam int ROW_W   = MAX_WAYS * (1 + AGE_W + ADDR_WIDTH);
   localparam int RSP_W   = ((3*COUNT_WIDTH+7)/8)*8;

   // configuration
   logic [2:0] set_bits_ff;
   logic [3:0] ways_ff;
   logic [4:0] block_bits_ff;
   logic       csr_wr;
   logic       csr_known;

   // clearing sweep
   logic             clr_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   // lookup stage
   logic             busy_ff;
   action_type       act_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic [IDX_W-1:0] set_ff;
   logic             fwd_ff;
   logic [ROW_W-1:0] fwd_row_ff;
   logic [ROW_W-1:0] rd_row_ff;

   // result
   logic             rsp_valid_ff;
   outcome_type      outcome_ff;
   logic             extra_ff;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;

   logic [ROW_W-1:0] set_mem [ROWS];

   // accept side
   logic                  req_acc;
   logic                  finishing;
   logic [ADDR_WIDTH-1:0] shifted;
   logic [SBE_W-1:0]      sb_eff;
   logic [IDX_W-1:0]      set_a;
   logic [ADDR_WIDTH-1:0] tag_a;

   // lookup logic
   logic [ROW_W-1:0]                       cur_row, new_row;
   logic [MAX_WAYS-1:0]                    cur_valid, new_valid;
   logic [MAX_WAYS-1:0][AGE_W-1:0]         cur_age, new_age;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]    cur_tag, new_tag;
   logic [MAX_WAYS-1:0]                    way_en;
   logic [WN_W-1:0]                        ways_eff;
   logic                                   hit, free;
   logic [AGE_W-1:0]                       hit_way, free_way, vic_way, way_sel;
   logic [OA_W-1:0]                        old_age;
   outcome_type                            outcome_c;
   logic [1:0]                             hit_inc;
   logic                                   miss_inc, evict_inc;
   logic                                   wr_en;
   logic [IDX_W-1:0]                       wr_addr;
   logic [ROW_W-1:0]                       wr_row;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [1:0] inc);
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, a} + (COUNT_WIDTH+1)'(inc);
      return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign csr_known = (csr_index == REG_SET_BITS) || (csr_index == REG_WAYS_IN_USE) ||
                      (csr_index == REG_BLOCK_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd0;
         ways_ff       <= 4'd1;
         block_bits_ff <= 5'd0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_SET_BITS:    set_bits_ff   <= csr_data[2:0];
            REG_WAYS_IN_USE: ways_ff       <= csr_data[3:0];
            REG_BLOCK_BITS:  block_bits_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (csr_wr && csr_known) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_ff     <= (clr_idx_ff != IDX_W'(ROWS - 1));
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // address split
   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = SBE_W'(MAX_SET_BITS);
      end else begin
         sb_eff = SBE_W'(set_bits_ff);
      end
      shifted = req_tdata[ADDR_WIDTH-1:0] >> block_bits_ff;
      set_a   = shifted[IDX_W-1:0] & ~({IDX_W{1'b1}} << sb_eff);
      tag_a   = shifted >> sb_eff;
   end

   assign finishing  = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_ff && (!busy_ff || finishing);
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         if (req_acc) begin
            busy_ff <= 1'b1;
            fwd_ff  <= finishing && wr_en && (wr_addr == set_a);
         end else if (finishing) begin
            busy_ff <= 1'b0;
            fwd_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         act_ff     <= action_type'(req_tuser);
         tag_ff     <= tag_a;
         set_ff     <= set_a;
         fwd_row_ff <= new_row;
      end
   end

   // set memory
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_row_ff <= set_mem[set_a];
      end
      if (wr_en) begin
         set_mem[wr_addr] <= wr_row;
      end
   end

   // lookup and LRU update
   assign cur_row = fwd_ff ? fwd_row_ff : rd_row_ff;
   assign {cur_tag, cur_age, cur_valid} = cur_row;

   always_comb begin
      if (ways_ff == 4'd0) begin
         ways_eff = WN_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WN_W'(MAX_WAYS);
      end else begin
         ways_eff = WN_W'(ways_ff);
      end
      for (int k = 0; k < MAX_WAYS; k++) begin
         way_en[k] = (k < int'(ways_eff));
      end
   end

   always_comb begin
      hit      = 1'b0;
      free     = 1'b0;
      hit_way  = '0;
      free_way = '0;
      vic_way  = '0;
      for (int k = MAX_WAYS - 1; k >= 0; k--) begin
         if (way_en[k] && cur_valid[k] && (cur_tag[k] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = AGE_W'(k);
         end
         if (way_en[k] && !cur_valid[k]) begin
            free     = 1'b1;
            free_way = AGE_W'(k);
         end
      end
      for (int k = 1; k < MAX_WAYS; k++) begin
         if (way_en[k] && (cur_age[k] > cur_age[vic_way])) begin
            vic_way = AGE_W'(k);
         end
      end

      if (hit) begin
         way_sel   = hit_way;
         old_age   = {1'b0, cur_age[hit_way]};
         outcome_c = OUT_HIT;
      end else if (free) begin
         way_sel   = free_way;
         old_age   = OA_W'(MAX_WAYS);
         outcome_c = OUT_MISS_FREE;
      end else begin
         way_sel   = vic_way;
         old_age   = {1'b0, cur_age[vic_way]};
         outcome_c = OUT_MISS_EVICT;
      end

      new_valid = cur_valid;
      new_tag   = cur_tag;
      for (int k = 0; k < MAX_WAYS; k++) begin
         new_age[k] = cur_age[k];
         if (way_en[k] && (AGE_W'(k) != way_sel) && cur_valid[k] &&
             ({1'b0, cur_age[k]} < old_age) && (int'(cur_age[k]) < MAX_WAYS - 1)) begin
            new_age[k] = cur_age[k] + 1'b1;
         end
      end
      new_age[way_sel]   = '0;
      new_valid[way_sel] = 1'b1;
      new_tag[way_sel]   = tag_ff;
      new_row = {new_tag, new_age, new_valid};

      if (act_ff == ACT_IFETCH) begin
         outcome_c = OUT_IGNORED;
      end
      // a modify adds a second lookup that always hits
      hit_inc   = 2'((outcome_c == OUT_HIT) ? 1 : 0) + 2'((act_ff == ACT_MODIFY) ? 1 : 0);
      miss_inc  = (outcome_c == OUT_MISS_FREE) || (outcome_c == OUT_MISS_EVICT);
      evict_inc = (outcome_c == OUT_MISS_EVICT);
   end

   always_comb begin
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_idx_ff;
         wr_row  = '0;
      end else begin
         wr_en   = finishing && (act_ff != ACT_IFETCH);
         wr_addr = set_ff;
         wr_row  = new_row;
      end
   end

   // results
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else if (finishing) begin
         rsp_valid_ff <= 1'b1;
         hit_cnt_ff   <= sat_add(hit_cnt_ff, hit_inc);
         miss_cnt_ff  <= sat_add(miss_cnt_ff, {1'b0, miss_inc});
         evict_cnt_ff <= sat_add(evict_cnt_ff, {1'b0, evict_inc});
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finishing) begin
         outcome_ff <= outcome_c;
         extra_ff   <= (act_ff == ACT_MODIFY);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {extra_ff, outcome_ff};
   assign rsp_tdata  = RSP_W'({evict_cnt_ff, miss_cnt_ff, hit_cnt_ff});

endmodule

// File: rtl/core/salc_checker.sv
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the cache core, attached by bind.
// ----------------------------------------------------------------------------
module salc_checker
   import salc_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [2:0]                            rsp_tuser,
   input logic [((3*COUNT_WIDTH+7)/8)*8-1:0]    rsp_tdata
);

   logic [COUNT_WIDTH-1:0] hits, misses, evicts;

   assign hits   = rsp_tdata[COUNT_WIDTH-1:0];
   assign misses = rsp_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
   assign evicts = rsp_tdata[3*COUNT_WIDTH-1:2*COUNT_WIDTH];

   // sweep runs straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready && !rsp_tvalid)
      else $error("item path live straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_ignored_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == OUT_IGNORED) |-> !rsp_tuser[2])
      else $error("ignored item reports extra hit");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser[1:0] == OUT_HIT) || rsp_tuser[2]) |-> (hits != '0))
      else $error("hit reported with zero hit count");

   a_evict_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == OUT_MISS_EVICT) |-> (evicts != '0) && (misses != '0))
      else $error("eviction reported with zero counts");

endmodule

bind set_assoc_lru_cache_sim_core salc_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_salc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb_set_assoc_lru_cache_sim_core.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim_core
// Self-checking bench for the set-associative LRU cache core: directed
// lookups, randomised traces over many cache shapes and output back-pressure.
// A behavioural cache with LRU ranks and saturating counters runs beside the
// core and predicts every result item, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_set_assoc_lru_cache_sim_core;
   import salc_pkg::*;

   localparam int  LINES      = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
   localparam int  CYCLE_LIMIT = 400000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      outcome_type outcome;
      logic        extra_hit;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evicts;
   } access_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // action[1:0]
   logic [47:0] req_tdata;   // address[47:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;   // outcome[1:0], extra_hit[2]
   logic [95:0] rsp_tdata;   // hit_count[31:0], miss_count[63:32], evict_count[95:64]
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow cache
   bit          cache_valid [LINES];
   logic [47:0] cache_tag   [LINES];
   int          cache_rank  [LINES];
   logic [31:0] hit_total, miss_total, evict_total;
   logic [2:0]  cfg_set_bits;
   logic [3:0]  cfg_ways;
   logic [4:0]  cfg_block_bits;

   access_result_type access_results_due[$];
   logic [63:0] tag_base;
   bit          req_gapless;
   bit          rsp_gapless;
   int          rsp_hold_cycles;
   int          errors;
   int          cycle_count;

   set_assoc_lru_cache_sim_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] sat_inc(logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

   function automatic int eff_set_bits();
      return (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg_set_bits);
   endfunction

   function automatic int eff_ways();
      if (cfg_ways == 0)
         return 1;
      return (cfg_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(cfg_ways);
   endfunction

   function automatic void clear_cache();
      for (int i = 0; i < LINES; i++) begin
         cache_valid[i] = 1'b0;
         cache_tag[i]   = '0;
         cache_rank[i]  = 0;
      end
   endfunction

   // way w becomes most recent; valid lines younger than old_rank age by one
   function automatic void promote_way(int base, int n, int w, int old_rank);
      for (int k = 0; k < n; k++) begin
         if (k != w && cache_valid[base+k] && cache_rank[base+k] < old_rank
             && cache_rank[base+k] < DEF_MAX_WAYS - 1)
            cache_rank[base+k]++;
      end
      cache_rank[base+w] = 0;
   endfunction

   function automatic outcome_type probe_set(int set_idx, logic [47:0] tag, int n);
      int base;
      int victim;
      base = set_idx * DEF_MAX_WAYS;
      for (int k = 0; k < n; k++) begin
         if (cache_valid[base+k] && cache_tag[base+k] == tag) begin
            promote_way(base, n, k, cache_rank[base+k]);
            hit_total = sat_inc(hit_total);
            return OUT_HIT;
         end
      end
      for (int k = 0; k < n; k++) begin
         if (!cache_valid[base+k]) begin
            promote_way(base, n, k, DEF_MAX_WAYS);
            cache_valid[base+k] = 1'b1;
            cache_tag[base+k]   = tag;
            miss_total = sat_inc(miss_total);
            return OUT_MISS_FREE;
         end
      end
      victim = 0;
      for (int k = 1; k < n; k++) begin
         if (cache_rank[base+k] > cache_rank[base+victim])
            victim = k;
      end
      promote_way(base, n, victim, cache_rank[base+victim]);
      cache_tag[base+victim] = tag;
      miss_total  = sat_inc(miss_total);
      evict_total = sat_inc(evict_total);
      return OUT_MISS_EVICT;
   endfunction

   function automatic access_result_type predict_access(action_type act, logic [47:0] addr);
      access_result_type r;
      int          sb;
      int          n;
      int          set_idx;
      logic [47:0] shifted;
      logic [47:0] tag;
      sb = eff_set_bits();
      n  = eff_ways();
      r.outcome   = OUT_IGNORED;
      r.extra_hit = 1'b0;
      if (act != ACT_IFETCH) begin
         shifted = addr >> cfg_block_bits;
         set_idx = int'(shifted & ((48'd1 << sb) - 48'd1));
         tag     = shifted >> sb;
         r.outcome = probe_set(set_idx, tag, n);
         if (act == ACT_MODIFY) begin
            void'(probe_set(set_idx, tag, n));
            r.extra_hit = 1'b1;
         end
      end
      r.hits   = hit_total;
      r.misses = miss_total;
      r.evicts = evict_total;
      return r;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
      case (idx)
         REG_SET_BITS:    cfg_set_bits   = value[2:0];
         REG_WAYS_IN_USE: cfg_ways       = value[3:0];
         REG_BLOCK_BITS:  cfg_block_bits = value[4:0];
         default:         return;
      endcase
      clear_cache();
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic action_type pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35)
         return ACT_LOAD;
      if (r < 65)
         return ACT_STORE;
      if (r < 90)
         return ACT_MODIFY;
      return ACT_IFETCH;
   endfunction

   // mostly a small working set of tags, half in two hot sets; one in ten is raw noise
   function automatic logic [47:0] pick_address();
      logic [63:0] raw;
      logic [63:0] tag;
      logic [63:0] set_idx;
      logic [63:0] offs;
      int          sb;
      sb  = eff_set_bits();
      raw = {$urandom(), $urandom()};
      if ($urandom_range(0, 9) == 0)
         return raw[47:0];
      tag = tag_base + 64'($urandom_range(0, eff_ways() + 1));
      if ($urandom_range(0, 1) == 0)
         set_idx = 64'($urandom_range(0, 1));
      else
         set_idx = 64'($urandom());
      set_idx = set_idx & ((64'd1 << sb) - 64'd1);
      offs    = raw & ((64'd1 << cfg_block_bits) - 64'd1);
      raw = (tag << (sb + cfg_block_bits)) | (set_idx << cfg_block_bits) | offs;
      return raw[47:0];
   endfunction

   task automatic send_access(input action_type act, input logic [47:0] addr);
      int gap;
      gap = req_gapless ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      access_results_due.insert(access_results_due.size(), predict_access(act, addr));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, value);
   endtask

   // writes all three registers while idle, and the unused index if asked; unused upper data bits are junk
   task automatic configure(input int sb, input int ways, input int bb,
                            input bit poke_unused);
      req_tvalid <= 1'b0;
      while (access_results_due.size() != 0)
         @(posedge clock);
      write_reg(REG_SET_BITS,    8'(sb)   | (8'($urandom()) & 8'hF8));
      write_reg(REG_WAYS_IN_USE, 8'(ways) | (8'($urandom()) & 8'hF0));
      write_reg(REG_BLOCK_BITS,  8'(bb)   | (8'($urandom()) & 8'hE0));
      if (poke_unused)
         write_reg(REG_UNUSED, 8'($urandom()));
      csr_valid <= 1'b0;
      tag_base = {$urandom(), $urandom()};
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_default_shape();
      send_access(ACT_LOAD,   48'h0);
      send_access(ACT_STORE,  48'h0);
      send_access(ACT_LOAD,   48'hFFFF_FFFF_FFFF);
      send_access(ACT_MODIFY, 48'hFFFF_FFFF_FFFF);
      send_access(ACT_MODIFY, 48'h0);
      send_access(ACT_IFETCH, 48'hFFFF_FFFF_FFFF);
      send_access(ACT_IFETCH, 48'h5555_5555_5555);
   endtask

   task automatic test_clamped_config();
      // set bits above the maximum, zero ways, wide block offset
      configure(7, 0, 16, 1'b1);
      send_access(ACT_LOAD,  48'hFFFF_FFFF_FFFF);
      send_access(ACT_STORE, 48'h0000_003F_0000);
      send_access(ACT_LOAD,  48'h0);
      send_access(ACT_LOAD,  48'hFFFF_FFFF_FFFF);
   endtask

   task automatic test_lru_order();
      // too many ways: clamps to full associativity, fill one set then evict
      configure(2, 15, 0, 1'b0);
      for (int k = 0; k <= DEF_MAX_WAYS; k++)
         send_access(ACT_LOAD, 48'((k << 2) | 1));
      send_access(ACT_LOAD,   48'h1);
      send_access(ACT_STORE,  48'((5 << 2) | 1));
      send_access(ACT_MODIFY, 48'((DEF_MAX_WAYS << 2) | 1));
   endtask

   task automatic test_random_traffic();
      int sb, ways, bb;
      for (int p = 0; p < 10; p++) begin
         case (p)
            0:       begin sb = 0; ways = 1;  bb = 0;  end
            1:       begin sb = 6; ways = 8;  bb = 0;  end
            2:       begin sb = 7; ways = 15; bb = 31; end
            3:       begin sb = 0; ways = 8;  bb = 4;  end
            4:       begin sb = 6; ways = 1;  bb = 16; end
            default: begin
               sb   = $urandom_range(0, 7);
               ways = $urandom_range(0, 15);
               bb   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 6);
            end
         endcase
         configure(sb, ways, bb, (p % 3) == 0);
         for (int i = 0; i < 110; i++) begin
            if (i % 20 == 0) begin
               req_gapless = ($urandom_range(0, 3) == 0);
               rsp_gapless = ($urandom_range(0, 3) == 0);
            end
            send_access(pick_action(), pick_address());
         end
      end
      req_gapless = 1'b0;
      rsp_gapless = 1'b0;
   endtask

   task automatic test_output_backpressure();
      configure(1, 2, 3, 1'b0);
      rsp_hold_cycles = 150;
      req_gapless = 1'b1;
      for (int i = 0; i < 40; i++)
         send_access(pick_action(), pick_address());
      req_gapless = 1'b0;
   endtask

   // ---------------------------------------------------------------- sink
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_gapless ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      access_result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (access_results_due.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            due = access_results_due.pop_front();
            if (rsp_tuser[1:0] !== due.outcome) begin
               $error("outcome: expected %0d, got %0d", due.outcome, rsp_tuser[1:0]);
               errors++;
            end
            if (rsp_tuser[2] !== due.extra_hit) begin
               $error("extra_hit: expected %0d, got %0d", due.extra_hit, rsp_tuser[2]);
               errors++;
            end
            if (rsp_tdata[31:0] !== due.hits) begin
               $error("hit_count: expected %0d, got %0d", due.hits, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== due.misses) begin
               $error("miss_count: expected %0d, got %0d", due.misses, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== due.evicts) begin
               $error("evict_count: expected %0d, got %0d", due.evicts, rsp_tdata[95:64]);
               errors++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tuser       = ACT_LOAD;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_index       = REG_SET_BITS;
      csr_data        = '0;
      req_gapless     = 1'b0;
      rsp_gapless     = 1'b0;
      rsp_hold_cycles = 0;
      errors          = 0;
      tag_base        = '0;
      clear_cache();
      hit_total       = '0;
      miss_total      = '0;
      evict_total     = '0;
      cfg_set_bits    = 3'd0;
      cfg_ways        = 4'd1;
      cfg_block_bits  = 5'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_shape();
      test_clamped_config();
      test_lru_order();
      test_random_traffic();
      test_output_backpressure();

      req_tvalid <= 1'b0;
      while (access_results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
